// ===== rtl/core/sqek_pkg.sv =====
// sqek_pkg: shared types and constants of the squared-exponential kernel unit.
// Used by sqek_csr, sqek_ctrl, sqek_dp and sq_exp_kernel_entry_unit; no dependencies.
package sqek_pkg;

   localparam int FCNT_W = 9;
   localparam int D2_W   = 48;
   localparam int PACC_W = 81;
   localparam int X_W    = 23;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [2:0] CSR_IL0  = 3'd0;
   localparam logic [2:0] CSR_IL1  = 3'd1;
   localparam logic [2:0] CSR_IL2  = 3'd2;
   localparam logic [2:0] CSR_IL3  = 3'd3;
   localparam logic [2:0] CSR_AMP  = 3'd4;
   localparam logic [2:0] CSR_NOIS = 3'd5;
   localparam logic [2:0] CSR_FCNT = 3'd6;
   localparam logic [2:0] CSR_CCNT = 3'd7;

   localparam logic [31:0] Q30_ONE   = 32'd1073741824;
   localparam logic [31:0] Q30_HALF  = 32'd536870912;
   localparam logic [31:0] Q30_SIXTH = 32'd178956971;
   localparam logic [31:0] Q30_TWF   = 32'd44739242;
   localparam logic [31:0] LOG2E_Q16 = 32'd94548;
   localparam logic [31:0] LN2_Q30   = 32'd744261118;
   localparam logic [X_W-1:0] X_CAP  = 23'd4194304;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FEAT,
      S_DRAIN,
      S_MUL,
      S_WB
   } state_type;

   typedef enum logic [3:0] {
      MOP_NONE,
      MOP_IL2,
      MOP_P0,
      MOP_P1,
      MOP_P2,
      MOP_Y,
      MOP_S,
      MOP_T1,
      MOP_T2,
      MOP_T3,
      MOP_P,
      MOP_M,
      MOP_A2,
      MOP_COV
   } mop_type;

   typedef struct packed {
      logic [3:0][15:0]  inv_len;
      logic [15:0]       amplitude;
      logic [15:0]       diag_noise;
      logic [FCNT_W-1:0] nfeat;
      logic [2:0]        ncls;
   } cfg_type;

   typedef struct packed {
      logic              load_en;
      logic              query_en;
      logic              class_err;
      logic              feat_en;
      logic [FCNT_W-1:0] feat_slot;
      mop_type           mul_op;
      mop_type           wb_op;
   } cmd_type;

   function automatic mop_type next_mop(input mop_type op);
      mop_type r;
      unique case (op)
         MOP_IL2: r = MOP_P0;
         MOP_P0:  r = MOP_P1;
         MOP_P1:  r = MOP_P2;
         MOP_P2:  r = MOP_Y;
         MOP_Y:   r = MOP_S;
         MOP_S:   r = MOP_T1;
         MOP_T1:  r = MOP_T2;
         MOP_T2:  r = MOP_T3;
         MOP_T3:  r = MOP_P;
         MOP_P:   r = MOP_M;
         MOP_M:   r = MOP_A2;
         MOP_A2:  r = MOP_COV;
         default: r = MOP_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] quarter_pow(input logic [1:0] q);
      logic [31:0] r;
      unique case (q)
         2'd0: r = 32'd1073741824;
         2'd1: r = 32'd902905651;
         2'd2: r = 32'd759250125;
         2'd3: r = 32'd638450708;
         default: r = 32'd1073741824;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/sqek_csr.sv =====
// sqek_csr: configuration registers of the kernel unit, with clamped counts.
// Depends on sqek_pkg.
module sqek_csr #(
   parameter int MAX_FEATURES = 16,
   parameter int MAX_CLASSES  = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output sqek_pkg::cfg_type cfg
);

   logic [3:0][15:0] il_ff, il_in;
   logic [15:0] amp_ff, amp_in, noise_ff, noise_in;
   logic [4:0]  fcnt_ff, fcnt_in;
   logic [2:0]  ccnt_ff, ccnt_in;

   assign csr_ready = 1'b1;

   always_comb begin
      il_in    = il_ff;
      amp_in   = amp_ff;
      noise_in = noise_ff;
      fcnt_in  = fcnt_ff;
      ccnt_in  = ccnt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sqek_pkg::CSR_IL0:  il_in[0] = csr_data;
            sqek_pkg::CSR_IL1:  il_in[1] = csr_data;
            sqek_pkg::CSR_IL2:  il_in[2] = csr_data;
            sqek_pkg::CSR_IL3:  il_in[3] = csr_data;
            sqek_pkg::CSR_AMP:  amp_in   = csr_data;
            sqek_pkg::CSR_NOIS: noise_in = csr_data;
            sqek_pkg::CSR_FCNT: fcnt_in  = csr_data[4:0];
            sqek_pkg::CSR_CCNT: ccnt_in  = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         il_ff    <= {4{16'd256}};
         amp_ff   <= 16'd256;
         noise_ff <= 16'd0;
         fcnt_ff  <= 5'd16;
         ccnt_ff  <= 3'd4;
      end else begin
         il_ff    <= il_in;
         amp_ff   <= amp_in;
         noise_ff <= noise_in;
         fcnt_ff  <= fcnt_in;
         ccnt_ff  <= ccnt_in;
      end
   end

   always_comb begin
      cfg.inv_len    = il_ff;
      cfg.amplitude  = amp_ff;
      cfg.diag_noise = noise_ff;
      cfg.nfeat      = (32'(fcnt_ff) > MAX_FEATURES) ? sqek_pkg::FCNT_W'(MAX_FEATURES)
                                                     : sqek_pkg::FCNT_W'(fcnt_ff);
      cfg.ncls       = (32'(ccnt_ff) > MAX_CLASSES) ? 3'(MAX_CLASSES) : ccnt_ff;
   end

endmodule

// ===== rtl/core/sqek_ctrl.sv =====
// sqek_ctrl: sequencer of the kernel unit; feature sweep, drain, multiply steps.
// Depends on sqek_pkg; drives sqek_dp through cmd_type.
module sqek_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_opcode,
   input  logic [1:0]        req_class_sel,
   input  sqek_pkg::cfg_type cfg,
   output logic              busy,
   output logic              rsp_valid,
   output sqek_pkg::cmd_type cmd
);

   sqek_pkg::state_type state_ff, state_in;
   sqek_pkg::mop_type   op_ff, op_in;
   logic [sqek_pkg::FCNT_W-1:0] slot_ff, slot_in;
   logic [1:0] drain_ff, drain_in;
   logic       rsp_ff, rsp_in;
   logic       accept, class_err;

   assign accept    = start && (state_ff == sqek_pkg::S_IDLE);
   assign class_err = {1'b0, req_class_sel} >= cfg.ncls;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      slot_in  = slot_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         sqek_pkg::S_IDLE: begin
            if (accept && req_opcode == sqek_pkg::OP_QUERY && !class_err) begin
               slot_in  = '0;
               drain_in = '0;
               op_in    = sqek_pkg::MOP_IL2;
               state_in = (cfg.nfeat == '0) ? sqek_pkg::S_DRAIN : sqek_pkg::S_FEAT;
            end
         end
         sqek_pkg::S_FEAT: begin
            slot_in = slot_ff + 1'b1;
            if (slot_ff == cfg.nfeat - 1'b1) state_in = sqek_pkg::S_DRAIN;
         end
         sqek_pkg::S_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd2) state_in = sqek_pkg::S_MUL;
         end
         sqek_pkg::S_MUL: state_in = sqek_pkg::S_WB;
         sqek_pkg::S_WB: begin
            if (op_ff == sqek_pkg::MOP_COV) begin
               state_in = sqek_pkg::S_IDLE;
            end else begin
               op_in    = sqek_pkg::next_mop(op_ff);
               state_in = sqek_pkg::S_MUL;
            end
         end
         default: state_in = sqek_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      busy          = (state_ff != sqek_pkg::S_IDLE);
      cmd.load_en   = accept && req_opcode == sqek_pkg::OP_LOAD;
      cmd.query_en  = accept && req_opcode == sqek_pkg::OP_QUERY;
      cmd.class_err = class_err;
      cmd.feat_en   = (state_ff == sqek_pkg::S_FEAT);
      cmd.feat_slot = slot_ff;
      cmd.mul_op    = (state_ff == sqek_pkg::S_MUL) ? op_ff : sqek_pkg::MOP_NONE;
      cmd.wb_op     = (state_ff == sqek_pkg::S_WB)  ? op_ff : sqek_pkg::MOP_NONE;
      rsp_in        = (cmd.query_en && class_err) ||
                      (state_ff == sqek_pkg::S_WB && op_ff == sqek_pkg::MOP_COV);
      rsp_valid     = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqek_pkg::S_IDLE;
         op_ff    <= sqek_pkg::MOP_NONE;
         slot_ff  <= '0;
         drain_ff <= '0;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         slot_ff  <= slot_in;
         drain_ff <= drain_in;
         rsp_ff   <= rsp_in;
      end
   end

endmodule

// ===== rtl/core/sqek_dp.sv =====
// sqek_dp: feature store, distance pipeline and shared 32x32 multiplier datapath.
// Depends on sqek_pkg; sequenced by sqek_ctrl.
module sqek_dp #(
   parameter int MAX_ROWS     = 256,
   parameter int MAX_FEATURES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  sqek_pkg::cmd_type  cmd,
   input  sqek_pkg::cfg_type  cfg,
   input  logic [7:0]         req_row_a,
   input  logic [7:0]         req_row_b,
   input  logic [3:0]         req_feature_slot,
   input  logic signed [15:0] req_feature_value,
   input  logic [1:0]         req_class_sel,
   output logic [31:0]        rsp_covariance,
   output logic               rsp_class_error
);

   localparam int DEPTH = MAX_ROWS * MAX_FEATURES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [15:0] mem [DEPTH];

   logic [7:0]  row_a_ff, row_b_ff;
   logic        aoob_ff, boob_ff, diag_ff;
   logic [1:0]  csel_ff;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic        wr_ok;
   logic [15:0] rd_a_ff, rd_b_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic signed [16:0] diff;
   logic [15:0] ad_ff, ad_in;
   logic [31:0] sq_ff;
   logic [sqek_pkg::D2_W-1:0] d2_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;
   logic [31:0] il2_ff, s_ff, t_ff;
   logic [sqek_pkg::PACC_W-1:0] pacc_ff, pacc_sum;
   logic [sqek_pkg::X_W-1:0] x_ff, y_ff;
   logic [63:0] px;
   logic [30:0] m_val;
   logic [6:0]  n_val;
   logic [33:0] cov_sum;
   logic [31:0] cov_ff;
   logic        err_ff;

   assign wr_addr   = AW'(32'(req_row_a) * MAX_FEATURES + 32'(req_feature_slot));
   assign wr_ok     = (32'(req_row_a) < MAX_ROWS) && (32'(req_feature_slot) < MAX_FEATURES);
   assign rd_addr_a = AW'(32'(row_a_ff) * MAX_FEATURES + 32'(cmd.feat_slot));
   assign rd_addr_b = AW'(32'(row_b_ff) * MAX_FEATURES + 32'(cmd.feat_slot));

   always_ff @(posedge clock) begin
      if (cmd.load_en && wr_ok) mem[wr_addr] <= req_feature_value;
      if (cmd.feat_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_en) begin
         row_a_ff <= req_row_a;
         row_b_ff <= req_row_b;
         aoob_ff  <= !(32'(req_row_a) < MAX_ROWS);
         boob_ff  <= !(32'(req_row_b) < MAX_ROWS);
         diag_ff  <= (req_row_a == req_row_b);
         csel_ff  <= req_class_sel;
      end
   end

   always_comb begin
      diff  = (aoob_ff ? 17'sd0 : 17'(signed'(rd_a_ff))) -
              (boob_ff ? 17'sd0 : 17'(signed'(rd_b_ff)));
      ad_in = diff[16] ? 16'(-diff) : diff[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.feat_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ad_ff <= ad_in;
      sq_ff <= ad_ff * ad_ff;
      if (cmd.query_en) d2_ff <= '0;
      else if (v3_ff) d2_ff <= d2_ff + sqek_pkg::D2_W'(sq_ff);
   end

   always_comb begin
      unique case (cmd.mul_op)
         sqek_pkg::MOP_IL2: begin
            mul_a = 32'(cfg.inv_len[csel_ff]);
            mul_b = 32'(cfg.inv_len[csel_ff]);
         end
         sqek_pkg::MOP_P0: begin mul_a = il2_ff; mul_b = 32'(d2_ff[15:0]); end
         sqek_pkg::MOP_P1: begin mul_a = il2_ff; mul_b = 32'(d2_ff[31:16]); end
         sqek_pkg::MOP_P2: begin mul_a = il2_ff; mul_b = 32'(d2_ff[47:32]); end
         sqek_pkg::MOP_Y:  begin mul_a = 32'(x_ff); mul_b = sqek_pkg::LOG2E_Q16; end
         sqek_pkg::MOP_S:  begin mul_a = 32'(y_ff[13:0]); mul_b = sqek_pkg::LN2_Q30; end
         sqek_pkg::MOP_T1: begin mul_a = s_ff; mul_b = sqek_pkg::Q30_TWF; end
         sqek_pkg::MOP_T2,
         sqek_pkg::MOP_T3,
         sqek_pkg::MOP_P:  begin mul_a = s_ff; mul_b = t_ff; end
         sqek_pkg::MOP_M:  begin mul_a = sqek_pkg::quarter_pow(y_ff[15:14]); mul_b = t_ff; end
         sqek_pkg::MOP_A2: begin mul_a = 32'(cfg.amplitude); mul_b = 32'(cfg.amplitude); end
         sqek_pkg::MOP_COV: begin mul_a = il2_ff; mul_b = t_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      pacc_sum = '0;
      unique case (cmd.wb_op)
         sqek_pkg::MOP_P0: pacc_sum = pacc_ff + sqek_pkg::PACC_W'(prod_ff[47:0]);
         sqek_pkg::MOP_P1: pacc_sum = pacc_ff + (sqek_pkg::PACC_W'(prod_ff[47:0]) << 16);
         sqek_pkg::MOP_P2: pacc_sum = pacc_ff + (sqek_pkg::PACC_W'(prod_ff[47:0]) << 32);
         default:          pacc_sum = pacc_ff;
      endcase
      px      = pacc_sum[80:17];
      n_val   = y_ff[22:16];
      m_val   = 31'(prod_ff >> 30);
      cov_sum = 34'(prod_ff >> 30) + (diag_ff ? 34'(cfg.diag_noise) : 34'd0);
   end

   always_ff @(posedge clock) begin
      if (cmd.query_en) pacc_ff <= '0;
      unique case (cmd.wb_op)
         sqek_pkg::MOP_IL2,
         sqek_pkg::MOP_A2: il2_ff <= prod_ff[31:0];
         sqek_pkg::MOP_P0,
         sqek_pkg::MOP_P1: pacc_ff <= pacc_sum;
         sqek_pkg::MOP_P2:
            x_ff <= (px > 64'(sqek_pkg::X_CAP)) ? sqek_pkg::X_CAP : px[sqek_pkg::X_W-1:0];
         sqek_pkg::MOP_Y:  y_ff <= prod_ff[38:16];
         sqek_pkg::MOP_S:  s_ff <= 32'(prod_ff >> 16);
         sqek_pkg::MOP_T1: t_ff <= sqek_pkg::Q30_SIXTH - 32'(prod_ff >> 30);
         sqek_pkg::MOP_T2: t_ff <= sqek_pkg::Q30_HALF - 32'(prod_ff >> 30);
         sqek_pkg::MOP_T3,
         sqek_pkg::MOP_P:  t_ff <= sqek_pkg::Q30_ONE - 32'(prod_ff >> 30);
         sqek_pkg::MOP_M:  t_ff <= (n_val >= 7'd31) ? 32'd0 : 32'(m_val >> n_val);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.query_en && cmd.class_err) begin
         cov_ff <= '0;
         err_ff <= 1'b1;
      end else if (cmd.wb_op == sqek_pkg::MOP_COV) begin
         cov_ff <= (cov_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : cov_sum[31:0];
         err_ff <= 1'b0;
      end
   end

   assign rsp_covariance  = cov_ff;
   assign rsp_class_error = err_ff;

endmodule

// ===== rtl/core/sq_exp_kernel_entry_unit.sv =====
// sq_exp_kernel_entry_unit: top level of the squared-exponential kernel entry unit.
// Depends on sqek_pkg, sqek_csr, sqek_ctrl and sqek_dp.
//
// Usage:
//   A request is taken when start is high and busy is low. opcode 0 loads one
//   signed Q8.8 feature value into the store (row_a, feature_slot) and gives no
//   response. opcode 1 queries the kernel entry for rows row_a/row_b under
//   class_sel and gives one response on rsp_* for one cycle, marked by
//   rsp_valid; the receiver cannot stall it.
//   A query runs a feature sweep at one feature per cycle over a two-port store
//   read, a drain, then thirteen multiply steps on one shared 32x32 multiplier;
//   busy stays high while it runs.
//   A query with class_sel at or above class_count responds in the next cycle
//   with covariance 0 and class_error set, and busy stays low.
//   Registers are written through csr_valid/csr_index/csr_data; csr_ready is
//   always high. Write them only while busy is low.
//   Reset restores register defaults and idles the sequencer; the feature
//   store is not cleared and must be loaded before it is queried.
module sq_exp_kernel_entry_unit #(
   parameter int MAX_ROWS     = 256,
   parameter int MAX_FEATURES = 16,
   parameter int MAX_CLASSES  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [7:0]         req_row_a,
   input  logic [7:0]         req_row_b,
   input  logic [3:0]         req_feature_slot,
   input  logic signed [15:0] req_feature_value,
   input  logic [1:0]         req_class_sel,
   output logic               rsp_valid,
   output logic [31:0]        rsp_covariance,
   output logic               rsp_class_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   sqek_pkg::cfg_type cfg;
   sqek_pkg::cmd_type cmd;

   sqek_csr #(
      .MAX_FEATURES(MAX_FEATURES),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cfg      (cfg)
   );

   sqek_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_opcode   (req_opcode),
      .req_class_sel(req_class_sel),
      .cfg          (cfg),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .cmd          (cmd)
   );

   sqek_dp #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_FEATURES(MAX_FEATURES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_row_a        (req_row_a),
      .req_row_b        (req_row_b),
      .req_feature_slot (req_feature_slot),
      .req_feature_value(req_feature_value),
      .req_class_sel    (req_class_sel),
      .rsp_covariance   (rsp_covariance),
      .rsp_class_error  (rsp_class_error)
   );

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_error |-> rsp_covariance == 32'd0)
      else $error("class error response with nonzero covariance");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == sqek_pkg::OP_LOAD |=> !busy && !rsp_valid)
      else $error("load request produced activity");

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_error |-> !busy)
      else $error("class error response while busy");
`endif

endmodule

// ===== bench/tb_sq_exp_kernel_entry_unit.sv =====
// tb_sq_exp_kernel_entry_unit: self-checking bench for the squared-exponential kernel unit.
// Drives load/query requests and CSR writes and checks every response against a local
// predictor. Depends on sqek_pkg and sq_exp_kernel_entry_unit.
`timescale 1ns / 1ps

module tb_sq_exp_kernel_entry_unit;

   localparam int NROWS     = 256;
   localparam int NFEAT     = 16;
   localparam int SETTLE    = 60;
   localparam int MAX_CYC   = 1000000;
   localparam int PHASE_LEN = 125;

   typedef struct {
      logic        opcode;
      logic [7:0]  row_a;
      logic [7:0]  row_b;
      logic [3:0]  slot;
      logic [15:0] value;
      logic [1:0]  cls;
      int unsigned gap;
   } request_type;

   typedef struct packed {
      logic [31:0] cov;
      logic        err;
   } entry_type;

   localparam longint unsigned EXP2_FRAC [4] = '{
      64'd1073741824, 64'd902905651, 64'd759250125, 64'd638450708
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_opcode = sqek_pkg::OP_LOAD;
   logic [7:0] req_row_a = '0;
   logic [7:0] req_row_b = '0;
   logic [3:0] req_feature_slot = '0;
   logic signed [15:0] req_feature_value = '0;
   logic [1:0] req_class_sel = '0;
   logic rsp_valid;
   logic [31:0] rsp_covariance;
   logic rsp_class_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   sq_exp_kernel_entry_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_row_a(req_row_a), .req_row_b(req_row_b),
      .req_feature_slot(req_feature_slot), .req_feature_value(req_feature_value),
      .req_class_sel(req_class_sel), .rsp_valid(rsp_valid),
      .rsp_covariance(rsp_covariance), .rsp_class_error(rsp_class_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] feat_mem [NROWS*NFEAT];
   logic [15:0] inv_len [4];
   logic [15:0] amp;
   logic [15:0] noise;
   logic [4:0] feat_cnt;
   logic [2:0] cls_cnt;

   // generator shadow of which store entries hold data
   bit written [NROWS][NFEAT];
   logic [7:0] row_pool [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd253, 8'd254, 8'd255};

   request_type pending [$];
   entry_type expected [$];
   int errors = 0;
   int unsigned hold = 0;
   bit burst = 1'b0;
   request_type cur;

   initial begin
      for (int i = 0; i < 4; i++) inv_len[i] = 16'd256;
      amp = 16'd256;
      noise = 16'd0;
      feat_cnt = 5'd16;
      cls_cnt = 3'd4;
   end

   function automatic entry_type kernel_entry(logic [7:0] ra, logic [7:0] rb, logic [1:0] c);
      entry_type k;
      int ncls, nf, d;
      longint unsigned d2, il, x, y, n, q, r, s, t, p, m, e, a2, cov;
      logic [127:0] prod;
      ncls = (cls_cnt > 4) ? 4 : int'(cls_cnt);
      nf = (feat_cnt > NFEAT) ? NFEAT : int'(feat_cnt);
      k.err = 1'b0;
      k.cov = '0;
      if (int'(c) >= ncls) begin
         k.err = 1'b1;
         return k;
      end
      d2 = 0;
      for (int kk = 0; kk < nf; kk++) begin
         d = int'(feat_mem[ra*NFEAT+kk]) - int'(feat_mem[rb*NFEAT+kk]);
         d2 += longint'(d) * longint'(d);
      end
      il = 64'(inv_len[c]);
      prod = 128'(il * il) * 128'(d2);
      prod = prod >> 17;
      x = (prod > 128'(sqek_pkg::X_CAP)) ? 64'(sqek_pkg::X_CAP) : prod[63:0];
      y = (x * 64'(sqek_pkg::LOG2E_Q16)) >> 16;
      n = y >> 16;
      q = (y >> 14) & 64'd3;
      r = y & 64'h3FFF;
      s = (r * 64'(sqek_pkg::LN2_Q30)) >> 16;
      t = 64'(sqek_pkg::Q30_TWF);
      t = 64'(sqek_pkg::Q30_SIXTH) - ((s * t) >> 30);
      t = 64'(sqek_pkg::Q30_HALF) - ((s * t) >> 30);
      t = 64'(sqek_pkg::Q30_ONE) - ((s * t) >> 30);
      p = 64'(sqek_pkg::Q30_ONE) - ((s * t) >> 30);
      m = (EXP2_FRAC[q[1:0]] * p) >> 30;
      e = (n >= 64'd31) ? 64'd0 : (m >> n);
      a2 = longint'(amp) * longint'(amp);
      cov = (a2 * e) >> 30;
      if (ra == rb) cov += 64'(noise);
      k.cov = (cov > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cov[31:0];
      return k;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         hold = 0;
      end else begin
         if (start && !busy) begin
            if (req_opcode == sqek_pkg::OP_LOAD)
               feat_mem[req_row_a*NFEAT+req_feature_slot] = req_feature_value;
            else
               expected.push_back(kernel_entry(req_row_a, req_row_b, req_class_sel));
         end
         if (!start || !busy) begin
            if (hold > 0) begin
               hold--;
               start <= 1'b0;
            end else if (pending.size() > 0) begin
               cur = pending.pop_front();
               req_opcode <= cur.opcode;
               req_row_a <= cur.row_a;
               req_row_b <= cur.row_b;
               req_feature_slot <= cur.slot;
               req_feature_value <= cur.value;
               req_class_sel <= cur.cls;
               hold = cur.gap;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      entry_type want;
      if (!reset && rsp_valid) begin
         if (expected.size() == 0) begin
            $error("unexpected response cov=%h err=%b", rsp_covariance, rsp_class_error);
            errors++;
         end else begin
            want = expected.pop_front();
            if (rsp_covariance !== want.cov) begin
               $error("covariance: expected %h, got %h", want.cov, rsp_covariance);
               errors++;
            end
            if (rsp_class_error !== want.err) begin
               $error("class_error: expected %b, got %b", want.err, rsp_class_error);
               errors++;
            end
         end
      end
   end

   int unsigned cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYC) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      return burst ? 0 : $urandom_range(0, 9);
   endfunction

   task automatic push_load(logic [7:0] row, logic [3:0] slot, logic [15:0] val);
      request_type it;
      it.opcode = sqek_pkg::OP_LOAD;
      it.row_a = row;
      it.row_b = 8'($urandom_range(0, 255));
      it.slot = slot;
      it.value = val;
      it.cls = 2'($urandom_range(0, 3));
      it.gap = draw_gap();
      written[row][slot] = 1'b1;
      pending.push_back(it);
   endtask

   task automatic push_query(logic [7:0] ra, logic [7:0] rb, logic [1:0] c);
      request_type it;
      it.opcode = sqek_pkg::OP_QUERY;
      it.row_a = ra;
      it.row_b = rb;
      it.slot = 4'($urandom_range(0, 15));
      it.value = 16'($urandom);
      it.cls = c;
      it.gap = draw_gap();
      pending.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending.size() > 0 || start || expected.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sqek_pkg::CSR_IL0, sqek_pkg::CSR_IL1,
         sqek_pkg::CSR_IL2, sqek_pkg::CSR_IL3: inv_len[idx[1:0]] = val;
         sqek_pkg::CSR_AMP:  amp = val;
         sqek_pkg::CSR_NOIS: noise = val;
         sqek_pkg::CSR_FCNT: feat_cnt = val[4:0];
         sqek_pkg::CSR_CCNT: cls_cnt = val[2:0];
         default: ;
      endcase
   endtask

   task automatic csr_all(logic [15:0] il0, logic [15:0] il1, logic [15:0] il2,
                          logic [15:0] il3, logic [15:0] a, logic [15:0] nz,
                          logic [4:0] fc, logic [2:0] cc);
      wait_idle();
      csr_write(sqek_pkg::CSR_IL0, il0);
      csr_write(sqek_pkg::CSR_IL1, il1);
      csr_write(sqek_pkg::CSR_IL2, il2);
      csr_write(sqek_pkg::CSR_IL3, il3);
      csr_write(sqek_pkg::CSR_AMP, a);
      csr_write(sqek_pkg::CSR_NOIS, nz);
      csr_write(sqek_pkg::CSR_FCNT, 16'(fc));
      csr_write(sqek_pkg::CSR_CCNT, 16'(cc));
   endtask

   function automatic bit row_ready(logic [7:0] row);
      int nf;
      nf = (feat_cnt > NFEAT) ? NFEAT : int'(feat_cnt);
      for (int k = 0; k < nf; k++)
         if (!written[row][k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [15:0] draw_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'($urandom);
      if (r < 15) return (r & 1) ? 16'h7FFF : 16'h8000;
      return 16'($signed($urandom_range(0, 1023)) - 512);
   endfunction

   function automatic logic [15:0] draw_len();
      return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
   endfunction

   task automatic random_phase(int count);
      logic [7:0] ready [$];
      logic [7:0] ra, rb;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) burst = ~burst;
         ready.delete();
         foreach (row_pool[j]) if (row_ready(row_pool[j])) ready.push_back(row_pool[j]);
         if (ready.size() == 0 || $urandom_range(0, 99) < 35) begin
            ra = ($urandom_range(0, 99) < 85) ? row_pool[$urandom_range(0, 7)]
                                              : 8'($urandom_range(0, 255));
            push_load(ra, 4'($urandom_range(0, 15)), draw_value());
         end else begin
            ra = ready[$urandom_range(0, ready.size()-1)];
            rb = ($urandom_range(0, 3) == 0) ? ra : ready[$urandom_range(0, ready.size()-1)];
            push_query(ra, rb, 2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: two features per row, extremes and diagonal
      wait_idle();
      csr_write(sqek_pkg::CSR_FCNT, 16'd2);
      push_load(8'd0, 4'd0, 16'h7FFF);
      push_load(8'd0, 4'd1, 16'h8000);
      push_load(8'd255, 4'd0, 16'h8000);
      push_load(8'd255, 4'd1, 16'h7FFF);
      push_load(8'd1, 4'd0, 16'h0000);
      push_load(8'd1, 4'd1, 16'h0000);
      push_load(8'd2, 4'd0, 16'h0100);
      push_load(8'd2, 4'd1, 16'hFF00);
      push_query(8'd0, 8'd0, 2'd0);
      push_query(8'd0, 8'd255, 2'd1);
      push_query(8'd1, 8'd2, 2'd2);
      push_query(8'd2, 8'd1, 2'd3);
      push_query(8'd1, 8'd1, 2'd0);
      wait_idle();
      csr_write(sqek_pkg::CSR_NOIS, 16'hFFFF);
      csr_write(sqek_pkg::CSR_AMP, 16'hFFFF);
      csr_write(sqek_pkg::CSR_CCNT, 16'd2);
      push_query(8'd1, 8'd1, 2'd0);
      push_query(8'd1, 8'd2, 2'd1);
      push_query(8'd0, 8'd1, 2'd2);
      push_query(8'd2, 8'd2, 2'd3);
      csr_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 5'd0, 3'd0);
      push_query(8'd0, 8'd255, 2'd0);
      csr_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd0, 5'd2, 3'd4);
      push_query(8'd0, 8'd1, 2'd0);
      push_query(8'd0, 8'd1, 2'd3);

      // random phases with mixed settings
      csr_all(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 5'd1, 3'd1);
      random_phase(PHASE_LEN);
      csr_all(16'hFFFF, 16'd1, 16'd128, 16'd512, 16'd256, 16'd0, 5'd16, 3'd4);
      random_phase(PHASE_LEN);
      for (int ph = 0; ph < 3; ph++) begin
         csr_all(draw_len(), draw_len(), draw_len(), draw_len(),
                 16'($urandom), 16'($urandom), 5'($urandom_range(0, 16)),
                 3'($urandom_range(0, 4)));
         random_phase(PHASE_LEN);
      end
      csr_all(draw_len(), draw_len(), draw_len(), draw_len(),
              16'd300, 16'd77, 5'd31, 3'd7);
      random_phase(PHASE_LEN);

      wait_idle();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
